// ===== rtl/mlfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds field widths, register codes, the queue entry layout and enums.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

    localparam int ID_W    = 16;
    localparam int BURST_W = 24;
    localparam int TIME_W  = 32;
    localparam int AGE_W   = 32;
    localparam int NL_W    = 4;
    localparam int TQ_W    = 16;
    localparam int AL_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic OP_ARRIVE   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_THRESH  = 2'd2;

    localparam logic [NL_W-1:0] RST_NUM_LEVELS  = 4'd3;
    localparam logic [TQ_W-1:0] RST_TOP_QUANTUM = 16'd10;
    localparam logic [AL_W-1:0] RST_AGE_THRESH  = 24'd100;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] rem;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        logic [AGE_W-1:0]   age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SAT
    } t_alu_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ARR,
        ST_DSEL,
        ST_D_RD,
        ST_D_CMP,
        ST_D_CLK,
        ST_D_REM,
        ST_D_BACK,
        ST_D_TA,
        ST_D_WT,
        ST_AG_INIT,
        ST_AG_RD,
        ST_AG_ADD,
        ST_AG_CMP,
        ST_AG_BACK,
        ST_NS,
        ST_NS_DAT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/mlfq_if.sv =====
// Channel interfaces of the scheduler: process items, results, config writes.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mlfq_in_if import mlfq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst_len;
    logic [TIME_W-1:0]  arrive_time;
    modport source (output valid, operation, proc_id, burst_len, arrive_time, input ready);
    modport sink   (input valid, operation, proc_id, burst_len, arrive_time, output ready);
endinterface

interface mlfq_out_if import mlfq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    run_id;
    logic [2:0]         run_level;
    logic [TIME_W-1:0]  start_time;
    logic [BURST_W-1:0] run_length;
    logic               finished;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround;
    logic [BURST_W-1:0] next_slice;
    logic [TIME_W-1:0]  clock_now;
    logic               idle;
    logic               rejected;
    modport source (output valid, run_id, run_level, start_time, run_length, finished,
                    wait_time, turnaround, next_slice, clock_now, idle, rejected,
                    input ready);
    modport sink   (input valid, run_id, run_level, start_time, run_length, finished,
                    wait_time, turnaround, next_slice, clock_now, idle, rejected,
                    output ready);
endinterface

interface mlfq_cfg_if import mlfq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler_top.sv =====
// Multilevel feedback queue scheduler, top level: sequencer, queue pointers, result register.
// Depends on mlfq_pkg, mlfq_if, mlfq_ram and mlfq_alu.
//
// Usage:
//  - i_in carries one item per transfer: operation 0 queues a new process at
//    level 0, operation 1 runs the head of the highest non-empty level.
//  - o_res carries exactly one result per item, in item order.
//  - i_cfg writes num_levels (0), top_quantum (1) and age_thresh (2); write
//    only while no item is in flight. Other indexes are ignored.
// Flow: one item at a time; i_in.ready only in idle, and the next item can
// transfer in the cycle the result appears. A dispatch that runs a process
// also ages every process waiting in the lowest level, walking those entries
// one at a time through the entry RAM and the shared adder, so such a
// dispatch takes longer the more processes wait in the lowest level.
// Reset: synchronous, active low; all queues empty, clock 0, config
//  registers at 3 / 10 / 100. Queue entry storage is not cleared.
// Stall: a finished result sits in the output register; the next item is
//  still taken and worked, and only its final load waits for o_res.ready.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_queue_scheduler_top import mlfq_pkg::*; #(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mlfq_in_if.sink    i_in,
    mlfq_out_if.source o_res,
    mlfq_cfg_if.sink   i_cfg
);
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LAW = $clog2(MAX_LEVELS + 1);
    localparam int DW  = $clog2(LEVEL_DEPTH);
    localparam int CW  = $clog2(LEVEL_DEPTH + 1);
    localparam int AW  = LW + DW;

    // config
    logic [NL_W-1:0] r_num_levels;
    logic [TQ_W-1:0] r_top_quantum;
    logic [AL_W-1:0] r_age_thresh;

    // queue pointers, one set per level
    logic [DW-1:0] r_head  [MAX_LEVELS];
    logic [DW-1:0] r_tail  [MAX_LEVELS];
    logic [CW-1:0] r_count [MAX_LEVELS];

    // sequencer state
    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_clock, n_clock;
    logic               r_op, n_op;
    t_entry             r_ent, n_ent;     // item being run or queued
    t_entry             r_aent, n_aent;   // entry being aged
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [LW-1:0]      r_fb, n_fb;
    logic [BURST_W-1:0] r_len, n_len;
    logic               r_done, n_done;
    logic [TIME_W-1:0]  r_start, n_start;
    logic [TIME_W-1:0]  r_ta, n_ta;
    logic [TIME_W-1:0]  r_wt, n_wt;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_i, n_i;
    logic [BURST_W-1:0] r_ns, n_ns;
    logic               r_idle, n_idle;
    logic               r_rej, n_rej;
    logic               r_vld, n_vld;

    // queue access
    logic [LW-1:0]  q_sel;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           ram_we;
    t_entry         ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry         rd_ent;

    // shared unit
    t_alu_op           alu_op;
    logic [TIME_W-1:0] alu_a, alu_b, alu_y;
    logic              alu_borrow;

    // level bookkeeping
    logic [LAW-1:0]    act;
    logic [LW-1:0]     low;
    logic [LW-1:0]     fb_lvl;
    logic              fb_none;
    logic [TIME_W-1:0] slice_lvl, slice_fb;
    logic              accept;

    assign rd_ent = t_entry'(ram_rdata);
    assign accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // active level count, clamped to 1 .. MAX_LEVELS
    always_comb begin
        if (r_num_levels == '0) begin
            act = LAW'(1);
        end else if (5'(r_num_levels) > 5'(MAX_LEVELS)) begin
            act = LAW'(MAX_LEVELS);
        end else begin
            act = LAW'(r_num_levels);
        end
        low = LW'(act - LAW'(1));
    end

    // highest non-empty active level
    always_comb begin
        fb_lvl  = '0;
        fb_none = 1'b1;
        for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
            if (LAW'(k) < act && r_count[k] != '0) begin
                fb_lvl  = LW'(k);
                fb_none = 1'b0;
            end
        end
    end

    assign slice_lvl = TIME_W'(r_top_quantum) << r_lvl;
    assign slice_fb  = TIME_W'(r_top_quantum) << r_fb;
    assign q_full    = (r_count[q_sel] == CW'(LEVEL_DEPTH));

    mlfq_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    mlfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (1 << AW)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({q_sel, r_tail[q_sel]}),
        .i_wdata (ram_wdata),
        .i_raddr ({q_sel, r_head[q_sel]}),
        .o_rdata (ram_rdata)
    );

    // sequencer: next state and datapath controls
    always_comb begin
        n_state = r_state;
        n_clock = r_clock;
        n_op    = r_op;
        n_ent   = r_ent;
        n_aent  = r_aent;
        n_lvl   = r_lvl;
        n_fb    = r_fb;
        n_len   = r_len;
        n_done  = r_done;
        n_start = r_start;
        n_ta    = r_ta;
        n_wt    = r_wt;
        n_n     = r_n;
        n_i     = r_i;
        n_ns    = r_ns;
        n_idle  = r_idle;
        n_rej   = r_rej;
        n_vld   = r_vld && !o_res.ready;
        q_sel     = r_lvl;
        q_push    = 1'b0;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = r_ent;
        alu_op    = ALU_SUB;
        alu_a     = '0;
        alu_b     = '0;
        i_in.ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    n_op          = i_in.operation;
                    n_ent.id      = i_in.proc_id;
                    n_ent.rem     = i_in.burst_len;
                    n_ent.burst   = i_in.burst_len;
                    n_ent.arrival = i_in.arrive_time;
                    n_ent.age     = '0;
                    n_lvl   = '0;
                    n_len   = '0;
                    n_done  = 1'b0;
                    n_start = '0;
                    n_ta    = '0;
                    n_wt    = '0;
                    n_idle  = 1'b0;
                    n_rej   = 1'b0;
                    n_state = (i_in.operation == OP_DISPATCH) ? ST_DSEL : ST_ARR;
                end
            end
            ST_ARR: begin
                q_sel = '0;
                alu_a = r_clock;
                alu_b = r_ent.arrival;
                if (q_full) begin
                    n_rej = 1'b1;
                end else begin
                    // idle jump: clock moves up to the arrival
                    if (fb_none && alu_borrow) begin
                        n_clock = r_ent.arrival;
                    end
                    ram_we = 1'b1;
                    q_push = 1'b1;
                end
                n_state = ST_NS;
            end
            ST_DSEL: begin
                if (fb_none) begin
                    n_idle  = 1'b1;
                    n_state = ST_NS;
                end else begin
                    n_lvl   = fb_lvl;
                    n_state = ST_D_RD;
                end
            end
            ST_D_RD: begin
                q_pop   = 1'b1;
                n_state = ST_D_CMP;
            end
            ST_D_CMP: begin
                n_ent   = rd_ent;
                n_start = r_clock;
                alu_a   = slice_lvl;
                alu_b   = TIME_W'(rd_ent.rem);
                if (r_lvl == low || !alu_borrow) begin
                    n_done = 1'b1;
                    n_len  = rd_ent.rem;
                end else begin
                    n_done = 1'b0;
                    n_len  = slice_lvl[BURST_W-1:0];
                end
                n_state = ST_D_CLK;
            end
            ST_D_CLK: begin
                alu_op  = ALU_ADD;
                alu_a   = r_clock;
                alu_b   = TIME_W'(r_len);
                n_clock = alu_y;
                n_state = r_done ? ST_D_TA : ST_D_REM;
            end
            ST_D_REM: begin
                alu_a = TIME_W'(r_ent.rem);
                alu_b = TIME_W'(r_len);
                n_ent.rem = alu_y[BURST_W-1:0];
                n_ent.age = '0;
                ram_wdata = n_ent;
                q_sel     = r_lvl + LW'(1);
                if (!q_full) begin
                    ram_we  = 1'b1;
                    q_push  = 1'b1;
                    n_state = ST_AG_INIT;
                end else begin
                    n_state = ST_D_BACK;
                end
            end
            ST_D_BACK: begin
                // lower level full: back to the tail of its own level
                ram_we  = 1'b1;
                q_push  = 1'b1;
                n_state = ST_AG_INIT;
            end
            ST_D_TA: begin
                alu_a   = r_clock;
                alu_b   = r_ent.arrival;
                n_ta    = alu_y;
                n_state = ST_D_WT;
            end
            ST_D_WT: begin
                alu_a   = r_ta;
                alu_b   = TIME_W'(r_ent.burst);
                n_wt    = alu_y;
                n_state = ST_AG_INIT;
            end
            ST_AG_INIT: begin
                q_sel   = low;
                n_n     = r_count[low];
                n_i     = '0;
                n_state = (r_count[low] == '0) ? ST_NS : ST_AG_RD;
            end
            ST_AG_RD: begin
                q_sel   = low;
                q_pop   = 1'b1;
                n_state = ST_AG_ADD;
            end
            ST_AG_ADD: begin
                alu_op     = ALU_SAT;
                alu_a      = rd_ent.age;
                alu_b      = TIME_W'(r_len);
                n_aent     = rd_ent;
                n_aent.age = alu_y;
                n_state    = ST_AG_CMP;
            end
            ST_AG_CMP: begin
                alu_a     = TIME_W'(r_age_thresh);
                alu_b     = r_aent.age;
                ram_wdata = r_aent;
                q_sel     = (low != '0) ? low - LW'(1) : low;
                if (alu_borrow && low != '0 && !q_full) begin
                    ram_we  = 1'b1;
                    q_push  = 1'b1;
                    n_i     = r_i + CW'(1);
                    n_state = (r_i + CW'(1) == r_n) ? ST_NS : ST_AG_RD;
                end else begin
                    n_state = ST_AG_BACK;
                end
            end
            ST_AG_BACK: begin
                q_sel     = low;
                ram_wdata = r_aent;
                ram_we    = 1'b1;
                q_push    = 1'b1;
                n_i       = r_i + CW'(1);
                n_state   = (r_i + CW'(1) == r_n) ? ST_NS : ST_AG_RD;
            end
            ST_NS: begin
                if (fb_none) begin
                    n_ns    = '0;
                    n_state = ST_OUT;
                end else begin
                    q_sel   = fb_lvl;   // head read issued here
                    n_fb    = fb_lvl;
                    n_state = ST_NS_DAT;
                end
            end
            ST_NS_DAT: begin
                alu_a = slice_fb;
                alu_b = TIME_W'(rd_ent.rem);
                if (r_fb == low || !alu_borrow) begin
                    n_ns = rd_ent.rem;
                end else begin
                    n_ns = slice_fb[BURST_W-1:0];
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_vld || o_res.ready) begin
                    n_vld   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_vld         <= 1'b0;
            r_clock       <= '0;
            r_num_levels  <= RST_NUM_LEVELS;
            r_top_quantum <= RST_TOP_QUANTUM;
            r_age_thresh  <= RST_AGE_THRESH;
            for (int k = 0; k < MAX_LEVELS; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_clock <= n_clock;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_NUM_LEVELS:  r_num_levels  <= i_cfg.data[NL_W-1:0];
                    CFG_TOP_QUANTUM: r_top_quantum <= i_cfg.data[TQ_W-1:0];
                    CFG_AGE_THRESH:  r_age_thresh  <= i_cfg.data[AL_W-1:0];
                    default: ;
                endcase
            end
            if (q_pop) begin
                r_head[q_sel]  <= (r_head[q_sel] == DW'(LEVEL_DEPTH - 1)) ? '0
                                  : r_head[q_sel] + DW'(1);
                r_count[q_sel] <= r_count[q_sel] - CW'(1);
            end
            if (q_push) begin
                r_tail[q_sel]  <= (r_tail[q_sel] == DW'(LEVEL_DEPTH - 1)) ? '0
                                  : r_tail[q_sel] + DW'(1);
                r_count[q_sel] <= r_count[q_sel] + CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_ent   <= n_ent;
        r_aent  <= n_aent;
        r_lvl   <= n_lvl;
        r_fb    <= n_fb;
        r_len   <= n_len;
        r_done  <= n_done;
        r_start <= n_start;
        r_ta    <= n_ta;
        r_wt    <= n_wt;
        r_n     <= n_n;
        r_i     <= n_i;
        r_ns    <= n_ns;
        r_idle  <= n_idle;
        r_rej   <= n_rej;
        if (r_state == ST_OUT && (!r_vld || o_res.ready)) begin
            o_res.run_id     <= (r_op == OP_DISPATCH && !r_idle) ? r_ent.id : '0;
            o_res.run_level  <= 3'(r_lvl);
            o_res.start_time <= r_start;
            o_res.run_length <= r_len;
            o_res.finished   <= r_done;
            o_res.wait_time  <= r_wt;
            o_res.turnaround <= r_ta;
            o_res.next_slice <= r_ns;
            o_res.clock_now  <= r_clock;
            o_res.idle       <= r_idle;
            o_res.rejected   <= r_rej;
        end
    end

    assign o_res.valid = r_vld;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[q_sel] <= CW'(LEVEL_DEPTH))
        else $error("level count above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

    a_idle_rej_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.idle && o_res.rejected))
        else $error("result both idle and rejected");

    a_unfinished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.finished) |-> (o_res.turnaround == '0 && o_res.wait_time == '0))
        else $error("times reported for unfinished run");

endmodule
`default_nettype wire

// ===== rtl/mlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/mlfq_alu.sv =====
// Shared 32-bit add / subtract / saturating add unit of the scheduler.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_alu import mlfq_pkg::*; (
    input  wire t_alu_op           i_op,
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    output logic      [TIME_W-1:0] o_y,
    output logic                   o_borrow
);
    logic [TIME_W:0] sum;
    logic [TIME_W:0] dif;

    always_comb begin
        sum = {1'b0, i_a} + {1'b0, i_b};
        dif = {1'b0, i_a} - {1'b0, i_b};
        o_borrow = dif[TIME_W];   // a < b
        case (i_op)
            ALU_ADD: o_y = sum[TIME_W-1:0];
            ALU_SUB: o_y = dif[TIME_W-1:0];
            ALU_SAT: o_y = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            default: o_y = sum[TIME_W-1:0];
        endcase
    end
endmodule
`default_nettype wire
